[sv/bblur_pkg.sv]
// ----------------------------------------------------------------------------
// bblur_pkg: shared types and constants of the 3x3 edge-aware box blur
// Item structs, state encoding, register indexes, reset values and the
// reciprocal table used to divide a window sum by its neighbor count.
// ----------------------------------------------------------------------------
package bblur_pkg;

    // Input item: one raster-order pixel
    typedef struct packed {
        logic [7:0] in_chan0;
        logic [7:0] in_chan1;
        logic [7:0] in_chan2;
        logic [7:0] in_chan3;
    } t_pix_in;

    // Output item: one blurred pixel with its position
    typedef struct packed {
        logic [7:0]  out_chan0;
        logic [7:0]  out_chan1;
        logic [7:0]  out_chan2;
        logic [7:0]  out_chan3;
        logic [11:0] out_row;
        logic [10:0] out_col;
        logic        frame_done;
    } t_pix_out;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SUM,
        ST_DIV
    } t_state;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    // Register reset values
    localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT  = 13'd480;
    localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd3;

    // Largest frame height
    localparam logic [12:0] ROW_LIMIT = 13'd4096;

    // Window sum: nine 8-bit samples
    localparam int SUM_W = 12;
    localparam int CNT_W = 4;

    // Reciprocals ceil(2^16 / n); exact for every sum up to 9 * 255
    localparam int RECIP_FRAC = 16;
    localparam int RECIP_W    = 17;
    localparam logic [RECIP_W-1:0] RECIP_TBL [16] = '{
        17'd65536, 17'd65536, 17'd32768, 17'd21846,
        17'd16384, 17'd13108, 17'd10923, 17'd9363,
        17'd8192,  17'd7282,  17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536
    };

endpackage

[sv/box_blur_3x3_edge_aware.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware: 3x3 mean blur with an edge-aware divisor
// Line memory holds the two previous rows; a 3x3 window feeds a shared
// sum and reciprocal-multiply unit that delivers up to four items per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) takes raster-order pixels.
//   Output channel (o_out_valid / i_out_ready / o_out) gives blurred pixels
//   tagged with row and column; frame_done marks the frame's last pixel.
//   A pixel's result leaves once its lower-right neighbor or the frame edge
//   has arrived, so one input item releases zero to four output items.
//   Config writes (i_cfg_wr_en, i_cfg_idx, i_cfg_wdata) set frame width,
//   height and channel count and restart the frame at row 0, column 0.
// Sequencing:
//   Each input item passes these steps in order: accept the item and read
//   the line memory, update the window and write back, then a sum step and
//   a divide step for each item that it releases, zero to four, in the
//   single shared arithmetic unit. The first output item is registered at
//   the end of the first divide step. The output register lets the next
//   pixel be accepted while the last item waits; a stalled receiver holds the divide step.
// Reset: counters and the sequencer clear; registers return to 640 x 480,
//   3 channels. The line memory is not cleared: it is only read for rows
//   above the frame before being written.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  bblur_pkg::t_pix_in               i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output bblur_pkg::t_pix_out              o_out,
    input  logic                             i_cfg_wr_en,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bblur_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = 8 * MAX_CHANNELS;
    localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;

    // Width register value to last column index, clamped
    function automatic logic [CW-1:0] clamp_width_m1(input logic [11:0] v);
        logic [WW-1:0] ve;
        ve = WW'(v);
        if (v == '0) begin
            return '0;
        end else if (ve > WW'(MAX_WIDTH)) begin
            return CW'(MAX_WIDTH - 1);
        end else begin
            return CW'(ve - WW'(1));
        end
    endfunction

    // Height register value to last row index, clamped
    function automatic logic [11:0] clamp_height_m1(input logic [12:0] v);
        if (v == '0) begin
            return '0;
        end else if (v > bblur_pkg::ROW_LIMIT) begin
            return 12'(bblur_pkg::ROW_LIMIT - 13'd1);
        end else begin
            return 12'(v - 13'd1);
        end
    endfunction

    // Channel count, clamped to the channels carried
    function automatic logic [2:0] clamp_chan(input logic [2:0] v);
        if (v > 3'(MAX_CHANNELS)) begin
            return 3'(MAX_CHANNELS);
        end else begin
            return v;
        end
    endfunction

    bblur_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_fw_last;
    logic [11:0]   r_fh_last;
    logic [2:0]    r_nch;

    logic [CW-1:0] r_col_cnt;
    logic [11:0]   r_row_cnt;

    logic [2*PW-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PW-1:0] r_rd;

    logic [PW-1:0] r_px;
    logic [CW-1:0] r_cur_col;
    logic [11:0]   r_cur_row;
    logic [PW-1:0] r_win [9];

    logic [3:0] r_pend;
    logic [3:0] shift_pend;

    logic [bblur_pkg::SUM_W-1:0] r_sum [4];
    logic [bblur_pkg::CNT_W-1:0] r_cnt;
    logic [11:0]                 r_tgt_row;
    logic [CW-1:0]               r_tgt_col;
    logic                        r_tgt_done;

    bblur_pkg::t_pix_out r_out, n_out;
    logic                r_out_valid;

    logic in_acc, out_free, cfg_hit;
    logic at_last_col, at_last_row, col_ge1, col_ge2, row_ge1, row_ge2;

    // Handshake
    assign o_in_ready  = (r_state == bblur_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Config index decode
    always_comb begin
        unique case (i_cfg_idx)
            bblur_pkg::CFG_FRAME_WIDTH,
            bblur_pkg::CFG_FRAME_HEIGHT,
            bblur_pkg::CFG_CHANNEL_COUNT: cfg_hit = i_cfg_wr_en;
            default:                      cfg_hit = 1'b0;
        endcase
    end

    // Config registers: width and height held as clamped last indexes, channel count clamped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_last <= clamp_width_m1(bblur_pkg::RST_FRAME_WIDTH);
            r_fh_last <= clamp_height_m1(bblur_pkg::RST_FRAME_HEIGHT);
            r_nch     <= clamp_chan(bblur_pkg::RST_CHANNEL_COUNT);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                bblur_pkg::CFG_FRAME_WIDTH:   r_fw_last <= clamp_width_m1(i_cfg_wdata[11:0]);
                bblur_pkg::CFG_FRAME_HEIGHT:  r_fh_last <= clamp_height_m1(i_cfg_wdata);
                bblur_pkg::CFG_CHANNEL_COUNT: r_nch     <= clamp_chan(i_cfg_wdata[2:0]);
                default: ;
            endcase
        end
    end

    // Position flags of the pixel being processed
    assign at_last_col = (r_cur_col == r_fw_last);
    assign at_last_row = (r_cur_row == r_fh_last);
    assign col_ge1     = (r_cur_col != '0);
    assign col_ge2     = (r_cur_col > CW'(1));
    assign row_ge1     = (r_cur_row != '0);
    assign row_ge2     = (r_cur_row > 12'd1);

    // Results released by this pixel, in raster order
    assign shift_pend = {at_last_row && at_last_col,
                         at_last_row && col_ge1,
                         row_ge1 && at_last_col,
                         row_ge1 && col_ge1};

    // Raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (cfg_hit) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (r_state == bblur_pkg::ST_SHIFT) begin
            if (at_last_col) begin
                r_col_cnt <= '0;
                r_row_cnt <= at_last_row ? 12'd0 : r_cur_row + 12'd1;
            end else begin
                r_col_cnt <= r_cur_col + CW'(1);
            end
        end
    end

    // Line memory: entry = {row r-1, row r-2}; read on accept, write back in shift
    always_ff @(posedge i_clk) begin
        if (r_state == bblur_pkg::ST_SHIFT) begin
            r_line_mem[r_cur_col] <= {r_px, r_rd[2*PW-1:PW]};
        end
        if (in_acc) begin
            r_rd <= r_line_mem[r_col_cnt];
        end
    end

    // Target selection and window sum
    logic [1:0]                  sel;
    logic                        sel_orow, sel_ocol;
    logic [2:0]                  row_mask, col_mask;
    logic [8:0]                  win_mask;
    logic [31:0]                 win_word;
    logic [bblur_pkg::SUM_W-1:0] sum_c [4];
    logic [bblur_pkg::CNT_W-1:0] cnt_c;

    always_comb begin
        if (r_pend[0]) begin
            sel = 2'd0;
        end else if (r_pend[1]) begin
            sel = 2'd1;
        end else if (r_pend[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        // target one row up / one column left of the newest pixel
        sel_orow = (sel == 2'd0) || (sel == 2'd1);
        sel_ocol = (sel == 2'd0) || (sel == 2'd2);
        row_mask = {1'b1, row_ge1, row_ge2 && sel_orow};
        col_mask = {1'b1, col_ge1, col_ge2 && sel_ocol};
        cnt_c    = '0;
        win_word = '0;
        for (int k = 0; k < 4; k++) begin
            sum_c[k] = '0;
        end
        for (int i = 0; i < 9; i++) begin
            win_mask[i] = row_mask[i / 3] && col_mask[i % 3];
            win_word    = 32'(r_win[i]);
            if (win_mask[i]) begin
                for (int k = 0; k < 4; k++) begin
                    sum_c[k] = sum_c[k] + bblur_pkg::SUM_W'(win_word[8*k +: 8]);
                end
                cnt_c = cnt_c + bblur_pkg::CNT_W'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px      <= PW'({i_in.in_chan3, i_in.in_chan2, i_in.in_chan1, i_in.in_chan0});
            r_cur_col <= r_col_cnt;
            r_cur_row <= r_row_cnt;
        end
        if (r_state == bblur_pkg::ST_SHIFT) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_rd[PW-1:0];
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= r_rd[2*PW-1:PW];
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_px;
        end
        if (r_state == bblur_pkg::ST_SUM) begin
            for (int k = 0; k < 4; k++) begin
                r_sum[k] <= sum_c[k];
            end
            r_cnt      <= cnt_c;
            r_tgt_row  <= r_cur_row - 12'(sel_orow);
            r_tgt_col  <= r_cur_col - CW'(sel_ocol);
            r_tgt_done <= (sel == 2'd3);
        end
    end

    // Divide by count through the reciprocal table
    logic [bblur_pkg::SUM_W+bblur_pkg::RECIP_W-1:0] prod [4];
    logic [7:0]                                     quo  [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k] = (bblur_pkg::SUM_W + bblur_pkg::RECIP_W)'(r_sum[k])
                    * (bblur_pkg::SUM_W + bblur_pkg::RECIP_W)'(bblur_pkg::RECIP_TBL[r_cnt]);
            quo[k]  = (3'(k) < r_nch) ? prod[k][bblur_pkg::RECIP_FRAC +: 8] : 8'd0;
        end
        n_out.out_chan0  = quo[0];
        n_out.out_chan1  = quo[1];
        n_out.out_chan2  = quo[2];
        n_out.out_chan3  = quo[3];
        n_out.out_row    = r_tgt_row;
        n_out.out_col    = 11'(r_tgt_col);
        n_out.frame_done = r_tgt_done;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == bblur_pkg::ST_DIV) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == bblur_pkg::ST_DIV) && out_free) begin
            r_out <= n_out;
        end
    end

    // Sequencer state and pending results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bblur_pkg::ST_IDLE;
            r_pend  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == bblur_pkg::ST_SHIFT) begin
                r_pend <= shift_pend;
            end else if (r_state == bblur_pkg::ST_SUM) begin
                r_pend[sel] <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bblur_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = bblur_pkg::ST_SHIFT;
                end
            end
            bblur_pkg::ST_SHIFT: begin
                n_state = (shift_pend != '0) ? bblur_pkg::ST_SUM : bblur_pkg::ST_IDLE;
            end
            bblur_pkg::ST_SUM: begin
                n_state = bblur_pkg::ST_DIV;
            end
            bblur_pkg::ST_DIV: begin
                if (out_free) begin
                    n_state = (r_pend != '0) ? bblur_pkg::ST_SUM : bblur_pkg::ST_IDLE;
                end
            end
            default: n_state = bblur_pkg::ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    // A sum step always has a target left to serve
    a_sum_has_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bblur_pkg::ST_SUM) |-> (r_pend != '0))
        else $error("sum step without a pending result");

    // Divisor is a neighbor count of 1 to 9
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bblur_pkg::ST_DIV) |-> (r_cnt >= 4'd1 && r_cnt <= 4'd9))
        else $error("neighbor count out of range");

    // Raster counters stay inside the frame
    a_cnt_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_cnt <= r_fw_last) && (r_row_cnt <= r_fh_last))
        else $error("raster counter beyond frame");

    // An accepted pixel goes straight to the window update
    a_accept_to_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == bblur_pkg::ST_SHIFT))
        else $error("accepted pixel did not reach window update");
`endif

endmodule
